### hdl/rss_pkg.sv
// Shared constants, types and state codes for the running size statistics unit.
package rss_pkg;

  localparam int CATEGORIES = 16;
  localparam int CAT_AW     = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;
  localparam int CAT_EW     = 16;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIV1 = 7'b0000010,
    ST_MAG2 = 7'b0000100,
    ST_MULT = 7'b0001000,
    ST_ACC  = 7'b0010000,
    ST_WORK = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

endpackage

### hdl/rss_divider.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module rss_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [63:0]        dividend,
  input  logic [31:0]        divisor,
  output rss_pkg::iter_stat_t stat,
  output logic [63:0]        quotient
);

  logic [31:0] rem;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic        run;
  logic        done;
  logic [32:0] rem_sh;
  logic        fit;

  assign rem_sh = {rem, quotient[63]};
  assign fit    = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 6'd63;
      end else if (run) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dsr      <= divisor;
      rem      <= '0;
    end else if (run) begin
      quotient <= {quotient[62:0], fit};
      rem      <= fit ? 32'(rem_sh - {1'b0, dsr}) : rem_sh[31:0];
    end
  end

  assign stat.busy = run;
  assign stat.done = done;

endmodule

### hdl/rss_sqrt.sv
// Digit-by-digit square root of a Q48.16 value, two radicand bits per cycle.
module rss_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [63:0]        value,
  output rss_pkg::iter_stat_t stat,
  output logic [39:0]        root
);

  logic [79:0] rad;
  logic [42:0] rem;
  logic [5:0]  cnt;
  logic        run;
  logic        done;
  logic [42:0] rem_sh;
  logic [42:0] trial;
  logic        fit;

  assign rem_sh = {rem[40:0], rad[79:78]};
  assign trial  = {1'b0, root, 2'b01};
  assign fit    = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 6'd39;
      end else if (run) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= {value, 16'd0};
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      rad  <= {rad[77:0], 2'b00};
      rem  <= fit ? (rem_sh - trial) : rem_sh;
      root <= {root[38:0], fit};
    end
  end

  assign stat.busy = run;
  assign stat.done = done;

endmodule

### hdl/running_size_statistics_unit.sv
// Top level: Welford running mean, variance, deviation and category histogram.
// Usage:
//   Input channel: in_valid/in_stall carry trade_size, category_index and
//   trade_time. A transfer happens when in_valid is high and in_stall low.
//   Output channel: out_valid/out_stall carry total_trades, mean_size,
//   size_variance, size_deviation, earliest_time and category_total.
//   One result per trade, in order.
//   Each trade passes through a mean division step, the second difference,
//   the product and the M2 update, a variance division (skipped for the
//   first trade), the root and a load step. The single divider and the
//   root unit are used in turn; one trade is in work at a time, so a new
//   trade is accepted only after the previous result has been loaded.
//   in_stall is high from the accepting edge until the result is loaded
//   into the output register; a result waiting there does not block the
//   next trade, which holds only at its own load step while out_stall is high.
//   Reset clears the counts, mean, M2, earliest time and histogram at once.
module running_size_statistics_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] trade_size,
  input  logic [3:0]  category_index,
  input  logic [39:0] trade_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] total_trades,
  output logic [31:0] mean_size,
  output logic [63:0] size_variance,
  output logic [39:0] size_deviation,
  output logic [39:0] earliest_time,
  output logic [31:0] category_total
);

  rss_pkg::state_t     state;
  rss_pkg::iter_stat_t div_stat;
  rss_pkg::iter_stat_t sqrt_stat;

  logic [31:0] trade_counter;
  logic [31:0] running_mean;
  logic [63:0] m2;
  logic [39:0] first_time;
  logic [31:0] hist [rss_pkg::CATEGORIES];

  logic [31:0] size_r;
  logic        neg;
  logic [31:0] mag1;
  logic [31:0] mag2;
  logic [63:0] prod;
  logic [31:0] cat_r;
  logic [63:0] var_r;

  logic        div_start;
  logic [63:0] div_dividend;
  logic [31:0] div_divisor;
  logic [63:0] div_q;
  logic        sqrt_start;
  logic [63:0] sqrt_value;
  logic [39:0] sqrt_root;
  logic        var_phase;

  logic        in_fire;
  logic        out_load;
  logic [31:0] n_next;
  logic [rss_pkg::CAT_EW-1:0] cat_ext;
  logic        cat_ok;
  logic [rss_pkg::CAT_AW-1:0] cat_a;
  logic [31:0] step;
  logic [31:0] mean_new;
  logic [64:0] m2_sum;

  assign in_stall = (state != rss_pkg::ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_load = (state == rss_pkg::ST_OUT) && (!out_valid || !out_stall);

  assign n_next   = (trade_counter == '1) ? trade_counter : trade_counter + 32'd1;
  assign cat_ext  = rss_pkg::CAT_EW'(category_index);
  assign cat_ok   = cat_ext < rss_pkg::CAT_EW'(rss_pkg::CATEGORIES);
  assign cat_a    = cat_ext[rss_pkg::CAT_AW-1:0];
  assign step     = div_q[31:0];
  assign mean_new = neg ? running_mean - step : running_mean + step;
  assign m2_sum   = {1'b0, m2} + {1'b0, prod};

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {32'd0, mag1};
    div_divisor  = trade_counter;
    sqrt_start   = 1'b0;
    sqrt_value   = var_r;
    if (state == rss_pkg::ST_DIV1 && var_phase == 1'b0 && !div_stat.busy && !div_stat.done) begin
      div_start = 1'b1;
    end
    if (state == rss_pkg::ST_WORK && var_phase == 1'b0) begin
      if (trade_counter > 32'd1) begin
        div_start    = 1'b1;
        div_dividend = m2;
        div_divisor  = trade_counter - 32'd1;
      end else begin
        sqrt_start = 1'b1;
        sqrt_value = '0;
      end
    end
    if (state == rss_pkg::ST_WORK && div_stat.done) begin
      sqrt_start = 1'b1;
      sqrt_value = div_q;
    end
  end

  rss_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_q)
  );

  rss_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (sqrt_value),
    .stat  (sqrt_stat),
    .root  (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rss_pkg::ST_IDLE;
      trade_counter <= '0;
      running_mean  <= '0;
      m2            <= '0;
      first_time    <= '0;
      out_valid     <= 1'b0;
      var_phase     <= 1'b0;
      for (int i = 0; i < rss_pkg::CATEGORIES; i++) begin
        hist[i] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        rss_pkg::ST_IDLE: begin
          if (in_fire) begin
            trade_counter <= n_next;
            if (first_time == '0 || (trade_time != '0 && trade_time < first_time)) begin
              first_time <= trade_time;
            end
            if (cat_ok && hist[cat_a] != '1) begin
              hist[cat_a] <= hist[cat_a] + 32'd1;
            end
            var_phase <= 1'b0;
            state     <= rss_pkg::ST_DIV1;
          end
        end
        rss_pkg::ST_DIV1: begin
          if (div_stat.done) begin
            running_mean <= mean_new;
            state        <= rss_pkg::ST_MAG2;
          end
        end
        rss_pkg::ST_MAG2: begin
          state <= rss_pkg::ST_MULT;
        end
        rss_pkg::ST_MULT: begin
          state <= rss_pkg::ST_ACC;
        end
        rss_pkg::ST_ACC: begin
          m2    <= m2_sum[64] ? '1 : m2_sum[63:0];
          state <= rss_pkg::ST_WORK;
        end
        rss_pkg::ST_WORK: begin
          var_phase <= 1'b1;
          if (sqrt_stat.done) begin
            state <= rss_pkg::ST_OUT;
          end
        end
        rss_pkg::ST_OUT: begin
          if (out_load) begin
            state <= rss_pkg::ST_IDLE;
          end
        end
        default: state <= rss_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      size_r <= trade_size;
      neg    <= trade_size < running_mean;
      mag1   <= (trade_size < running_mean) ? running_mean - trade_size
                                            : trade_size - running_mean;
      if (!cat_ok) begin
        cat_r <= '0;
      end else if (hist[cat_a] != '1) begin
        cat_r <= hist[cat_a] + 32'd1;
      end else begin
        cat_r <= hist[cat_a];
      end
    end
    if (state == rss_pkg::ST_MAG2) begin
      mag2 <= neg ? running_mean - size_r : size_r - running_mean;
    end
    if (state == rss_pkg::ST_MULT) begin
      prod <= ({32'd0, mag1} * {32'd0, mag2}) >> 16;
    end
    if (sqrt_start) begin
      var_r <= sqrt_value;
    end
    if (out_load) begin
      total_trades   <= trade_counter;
      mean_size      <= running_mean;
      size_variance  <= var_r;
      size_deviation <= sqrt_root;
      earliest_time  <= first_time;
      category_total <= cat_r;
    end
  end

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(div_stat.busy && sqrt_stat.busy))
    else $error("divider and root unit busy together");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == rss_pkg::ST_DIV1))
    else $error("accepted trade did not start the mean division");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == rss_pkg::ST_IDLE))
    else $error("result load did not raise out_valid");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (total_trades != '0))
    else $error("result with zero trade count");

endmodule
